// File: hdl/ssq_pkg.sv
package ssq_pkg;

  localparam int TIME_W     = 32;
  localparam int MS_W       = 32;
  localparam int STAGE_W    = 3;
  localparam int CYCLES_W   = 16;
  localparam int DELAY_W    = 24;
  localparam int TMO_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FILL     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BRINE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKWASH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RINSE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SERVICE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 3'd5;

  // stage codes
  localparam logic [STAGE_W-1:0] STAGE_FILL     = 3'd0;
  localparam logic [STAGE_W-1:0] STAGE_BRINE    = 3'd1;
  localparam logic [STAGE_W-1:0] STAGE_BACKWASH = 3'd2;
  localparam logic [STAGE_W-1:0] STAGE_RINSE    = 3'd3;
  localparam logic [STAGE_W-1:0] STAGE_SERVICE  = 3'd4;

  // day arithmetic: 86400 = 675 * 2^7
  localparam logic [TIME_W-1:0] SECS_PER_DAY  = 32'd86400;
  localparam logic [TIME_W-1:0] TWO_AM_SECS   = 32'd7200;
  localparam logic [TIME_W-1:0] NEXT_2AM_SECS = SECS_PER_DAY + TWO_AM_SECS;
  localparam int                DAY_REM_W     = 17;
  localparam logic [DAY_REM_W-1:0] SIX_AM_SECS = 17'd21600;
  localparam int                DAY_LSB       = 7;
  localparam int                DAY_HI_W      = TIME_W - DAY_LSB;
  localparam int                DAY_UNITS_W   = 10;
  localparam logic [DAY_UNITS_W-1:0] DAY_UNITS = 10'd675;
  // floor(x / 675) = (x * RECIP_M) >> RECIP_SH, exact for x < 2^25
  localparam int                RECIP_W       = 26;
  localparam logic [RECIP_W-1:0] RECIP_M      = 26'd50903317;
  localparam int                RECIP_SH      = 35;
  localparam int                PROD_W        = DAY_HI_W + RECIP_W;
  localparam int                QUOT_W        = 16;

  typedef struct packed {
    logic [DELAY_W-1:0] fill_delay;
    logic [DELAY_W-1:0] brine_delay;
    logic [DELAY_W-1:0] backwash_delay;
    logic [DELAY_W-1:0] rinse_delay;
    logic [DELAY_W-1:0] service_delay;
    logic [TMO_W-1:0]   gear_limit_ms;
  } cfg_t;

  localparam cfg_t CFG_RST = '{
    fill_delay:        24'd516,
    brine_delay:       24'd2280,
    backwash_delay:    24'd5160,
    rinse_delay:       24'd900,
    service_delay:     24'd345600,
    gear_limit_ms:     16'd3000
  };

  typedef struct packed {
    logic [TIME_W-1:0] now_seconds;
    logic [MS_W-1:0]   now_ms;
    logic              gear_level;
    logic              skip_request;
  } item_t;

  typedef struct packed {
    logic [STAGE_W-1:0]  stage_now;
    logic [TIME_W-1:0]   next_event;
    logic [CYCLES_W-1:0] service_cycles;
    logic                skip_pending;
    logic                waiting_gear;
    logic                await_open;
    logic                last_level;
    logic [MS_W-1:0]     wait_start;
    logic                timeout_flag;
    logic [TIME_W-1:0]   last_countdown;
  } state_t;

  localparam state_t STATE_RST = '{
    stage_now:      STAGE_FILL,
    next_event:     '0,
    service_cycles: '0,
    skip_pending:   1'b0,
    waiting_gear:   1'b0,
    await_open:     1'b0,
    last_level:     1'b1,
    wait_start:     '0,
    timeout_flag:   1'b0,
    last_countdown: '0
  };

  typedef struct packed {
    logic [STAGE_W-1:0]  stage;
    logic [TIME_W-1:0]   countdown;
    logic [TIME_W-1:0]   event_time;
    logic [CYCLES_W-1:0] cycle_count;
    logic                changing;
    logic                advanced;
    logic                gear_timeout;
  } result_t;

endpackage

// File: hdl/ssq_in_if.sv
interface ssq_in_if;
  logic                          valid;
  logic                          ready;
  logic [ssq_pkg::TIME_W-1:0]    now_seconds;
  logic [ssq_pkg::MS_W-1:0]      now_ms;
  logic                          gear_level;
  logic                          skip_request;

  modport source (output valid, now_seconds, now_ms, gear_level, skip_request, input ready);
  modport sink (input valid, now_seconds, now_ms, gear_level, skip_request, output ready);
endinterface

// File: hdl/ssq_out_if.sv
interface ssq_out_if;
  logic                           valid;
  logic                           ready;
  logic [ssq_pkg::STAGE_W-1:0]    stage;
  logic signed [ssq_pkg::TIME_W-1:0] countdown_seconds;
  logic [ssq_pkg::TIME_W-1:0]     event_time;
  logic [ssq_pkg::CYCLES_W-1:0]   cycle_count;
  logic                           changing;
  logic                           advanced;
  logic                           gear_timeout;

  modport source (output valid, stage, countdown_seconds, event_time, cycle_count, changing,
                  advanced, gear_timeout, input ready);
  modport sink (input valid, stage, countdown_seconds, event_time, cycle_count, changing,
                advanced, gear_timeout, output ready);
endinterface

// File: hdl/ssq_cfg.sv
module ssq_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [ssq_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ssq_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output ssq_pkg::cfg_t                    cfg
);

  ssq_pkg::cfg_t cfg_r;
  ssq_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        ssq_pkg::CFG_FILL:     cfg_nxt.fill_delay     = cfg_wdata;
        ssq_pkg::CFG_BRINE:    cfg_nxt.brine_delay    = cfg_wdata;
        ssq_pkg::CFG_BACKWASH: cfg_nxt.backwash_delay = cfg_wdata;
        ssq_pkg::CFG_RINSE:    cfg_nxt.rinse_delay    = cfg_wdata;
        ssq_pkg::CFG_SERVICE:  cfg_nxt.service_delay  = cfg_wdata;
        ssq_pkg::CFG_TIMEOUT:  cfg_nxt.gear_limit_ms  = cfg_wdata[ssq_pkg::TMO_W-1:0];
        default:               cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= ssq_pkg::CFG_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// File: hdl/ssq_step.sv
module ssq_step (
  input  ssq_pkg::item_t                 item,
  input  ssq_pkg::state_t                state,
  input  ssq_pkg::cfg_t                  cfg,
  output ssq_pkg::state_t                state_nxt,
  output ssq_pkg::result_t               res,
  output logic                           rnd_start,
  output logic [ssq_pkg::TIME_W-1:0]     rnd_time
);

  logic                          skip;
  logic                          done;
  logic                          advanced;
  logic [ssq_pkg::TIME_W-1:0]    diff;
  logic [ssq_pkg::MS_W-1:0]      elapsed;
  logic [ssq_pkg::STAGE_W-1:0]   stage_inc;
  logic [ssq_pkg::DELAY_W-1:0]   delay;
  logic [ssq_pkg::TIME_W-1:0]    sum;

  assign diff      = state.next_event - item.now_seconds;
  assign elapsed   = item.now_ms - state.wait_start;
  assign stage_inc = (state.stage_now == ssq_pkg::STAGE_SERVICE) ? ssq_pkg::STAGE_FILL
                                                                 : state.stage_now + 3'd1;

  always_comb begin
    unique case (stage_inc)
      ssq_pkg::STAGE_FILL:     delay = cfg.fill_delay;
      ssq_pkg::STAGE_BRINE:    delay = cfg.brine_delay;
      ssq_pkg::STAGE_BACKWASH: delay = cfg.backwash_delay;
      ssq_pkg::STAGE_RINSE:    delay = cfg.rinse_delay;
      default:                 delay = cfg.service_delay;
    endcase
  end

  assign sum      = item.now_seconds + ssq_pkg::TIME_W'(delay);
  assign rnd_time = sum;

  always_comb begin
    skip      = state.skip_pending | item.skip_request;
    done      = 1'b0;
    advanced  = 1'b0;
    rnd_start = 1'b0;
    state_nxt = state;
    state_nxt.skip_pending = skip;
    if (state.waiting_gear) begin
      // close then open; the level is only tracked while waiting
      if (item.gear_level != state.last_level) begin
        state_nxt.last_level = item.gear_level;
        if (!state.await_open && !item.gear_level) begin
          state_nxt.await_open = 1'b1;
        end else if (state.await_open && item.gear_level) begin
          state_nxt.await_open = 1'b0;
          done = 1'b1;
        end
      end
      if (done) begin
        state_nxt.waiting_gear = 1'b0;
      end else if (elapsed > ssq_pkg::MS_W'(cfg.gear_limit_ms)) begin
        state_nxt.await_open   = 1'b0;
        state_nxt.timeout_flag = 1'b1;
        state_nxt.waiting_gear = 1'b0;
      end
    end else begin
      state_nxt.last_countdown = diff;
      if ((diff == '0) || diff[ssq_pkg::TIME_W-1] || skip) begin
        state_nxt.skip_pending = 1'b0;
        state_nxt.stage_now    = stage_inc;
        state_nxt.next_event   = sum;
        if (stage_inc == ssq_pkg::STAGE_SERVICE) begin
          state_nxt.service_cycles = state.service_cycles + 16'd1;
          rnd_start = 1'b1;
        end
        state_nxt.waiting_gear = 1'b1;
        state_nxt.wait_start   = item.now_ms;
        advanced = 1'b1;
      end
    end
  end

  assign res.stage          = state_nxt.stage_now;
  assign res.countdown      = state_nxt.last_countdown;
  assign res.event_time     = state_nxt.next_event;
  assign res.cycle_count    = state_nxt.service_cycles;
  assign res.changing       = state_nxt.waiting_gear;
  assign res.advanced       = advanced;
  assign res.gear_timeout   = state_nxt.timeout_flag;

endmodule

// File: hdl/ssq_round.sv
module ssq_round (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [ssq_pkg::TIME_W-1:0]     t,
  output logic                           busy,
  output logic                           done,
  output logic [ssq_pkg::TIME_W-1:0]     result
);

  // step valids: time latched, quotient, remainder, result
  logic [3:0]                            vld_r;
  logic [ssq_pkg::TIME_W-1:0]            t_r;
  logic [ssq_pkg::QUOT_W-1:0]            q_r;
  logic [ssq_pkg::DAY_UNITS_W-1:0]       rem_r;
  logic [ssq_pkg::TIME_W-1:0]            res_r;

  logic [ssq_pkg::DAY_HI_W-1:0]          x;
  logic [ssq_pkg::PROD_W-1:0]            prod;
  logic [ssq_pkg::DAY_HI_W-1:0]          qd;
  logic [ssq_pkg::DAY_HI_W-1:0]          rem_full;
  logic [ssq_pkg::DAY_REM_W-1:0]         r_day;
  logic [ssq_pkg::TIME_W-1:0]            day_start;
  logic [ssq_pkg::TIME_W-1:0]            res_nxt;

  assign x        = t_r[ssq_pkg::TIME_W-1:ssq_pkg::DAY_LSB];
  assign prod     = ssq_pkg::PROD_W'(x) * ssq_pkg::PROD_W'(ssq_pkg::RECIP_M);
  assign qd       = ssq_pkg::DAY_HI_W'(q_r) * ssq_pkg::DAY_HI_W'(ssq_pkg::DAY_UNITS);
  assign rem_full = x - qd;
  assign r_day    = {rem_r, t_r[ssq_pkg::DAY_LSB-1:0]};
  assign day_start = t_r - ssq_pkg::TIME_W'(r_day);
  assign res_nxt  = day_start + ((r_day < ssq_pkg::SIX_AM_SECS) ? ssq_pkg::TWO_AM_SECS
                                                                : ssq_pkg::NEXT_2AM_SECS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[2:0], start};
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      t_r <= t;
    end
    q_r   <= prod[ssq_pkg::RECIP_SH +: ssq_pkg::QUOT_W];
    rem_r <= rem_full[ssq_pkg::DAY_UNITS_W-1:0];
    res_r <= res_nxt;
  end

  assign busy   = |vld_r;
  assign done   = vld_r[3];
  assign result = res_r;

endmodule

// File: hdl/softener_stage_sequencer.sv
// Stage sequencer for a water softener valve.
// in_chan (valid/ready) takes one poll item: wall time in seconds, a free
// running ms counter, the debounced gear level and a skip request.
// out_chan (valid/ready) gives one result item per poll: stage, countdown,
// next event time, service count and the changing/advanced/timeout flags.
// cfg_we/cfg_index/cfg_wdata write the five stage delays and the gear
// timeout; write only while no item is in flight.
// An accepted item passes the input register, then the result register;
// an item that enters the service stage is also held in the 2 AM rounding
// unit (reciprocal multiply, remainder, then the day sum), during which no
// item is stepped and in_chan.ready drops once the input register is full.
// Throughput: one item per cycle otherwise, while out_chan.ready stays high.
// Reset (synchronous, rst_n low) restores the register defaults, puts the
// sequencer in the fill stage with the next event at time 0 and empties
// both the input and result registers.
// If the receiver stalls, the result register holds its item and the input
// register still takes one more item before in_chan.ready drops.
module softener_stage_sequencer (
  input  logic                             clk,
  input  logic                             rst_n,
  ssq_in_if.sink                           in_chan,
  ssq_out_if.source                        out_chan,
  input  logic                             cfg_we,
  input  logic [ssq_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ssq_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  ssq_pkg::cfg_t                 cfg;
  ssq_pkg::item_t                item_r;
  ssq_pkg::state_t               state_r;
  ssq_pkg::state_t               state_nxt;
  ssq_pkg::result_t              res_r;
  ssq_pkg::result_t              res_nxt;
  logic                          in_valid_r;
  logic                          out_valid_r;
  logic                          rnd_start;
  logic [ssq_pkg::TIME_W-1:0]    rnd_time;
  logic                          rnd_busy;
  logic                          rnd_done;
  logic [ssq_pkg::TIME_W-1:0]    rnd_result;
  logic                          out_taken;
  logic                          step_go;
  logic                          in_take;

  ssq_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  ssq_step u_step (
    .item      (item_r),
    .state     (state_r),
    .cfg       (cfg),
    .state_nxt (state_nxt),
    .res       (res_nxt),
    .rnd_start (rnd_start),
    .rnd_time  (rnd_time)
  );

  ssq_round u_round (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (step_go & rnd_start),
    .t      (rnd_time),
    .busy   (rnd_busy),
    .done   (rnd_done),
    .result (rnd_result)
  );

  // result item is held back while its event time is being rounded
  assign out_taken = out_valid_r & ~rnd_busy & out_chan.ready;
  assign step_go   = in_valid_r & ~rnd_busy & (~out_valid_r | out_taken);
  assign in_take   = in_chan.valid & in_chan.ready;

  assign in_chan.ready = ~in_valid_r | step_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= ssq_pkg::STATE_RST;
    end else begin
      if (in_take) begin
        in_valid_r <= 1'b1;
      end else if (step_go) begin
        in_valid_r <= 1'b0;
      end
      if (step_go) begin
        out_valid_r <= 1'b1;
      end else if (out_taken) begin
        out_valid_r <= 1'b0;
      end
      if (step_go) begin
        state_r <= state_nxt;
      end
      if (rnd_done) begin
        state_r.next_event <= rnd_result;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.now_seconds  <= in_chan.now_seconds;
      item_r.now_ms       <= in_chan.now_ms;
      item_r.gear_level   <= in_chan.gear_level;
      item_r.skip_request <= in_chan.skip_request;
    end
    if (step_go) begin
      res_r <= res_nxt;
    end else if (rnd_done) begin
      res_r.event_time <= rnd_result;
    end
  end

  assign out_chan.valid             = out_valid_r & ~rnd_busy;
  assign out_chan.stage             = res_r.stage;
  assign out_chan.countdown_seconds = $signed(res_r.countdown);
  assign out_chan.event_time        = res_r.event_time;
  assign out_chan.cycle_count       = res_r.cycle_count;
  assign out_chan.changing          = res_r.changing;
  assign out_chan.advanced          = res_r.advanced;
  assign out_chan.gear_timeout      = res_r.gear_timeout;

  a_round_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    rnd_done |-> out_valid_r)
    else $error("rounding finished with no result item held");

  a_service_rounds: assert property (@(posedge clk) disable iff (!rst_n)
    (step_go && rnd_start) |=> (rnd_busy && state_r.stage_now == ssq_pkg::STAGE_SERVICE))
    else $error("service entry did not start the rounding unit");

  a_stage_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.stage_now <= ssq_pkg::STAGE_SERVICE)
    else $error("stage out of range");

  a_advance_waits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!res_r.advanced || res_r.changing))
    else $error("advanced item not waiting for the gear");

endmodule
